@@ rtl/ptsp_pkg.sv @@
`default_nettype none
package ptsp_pkg;

    localparam int COEF_W      = 48;
    localparam int ACC_W       = 64;
    localparam int STEP_W      = 32;
    localparam int COUNT_W     = 7;
    localparam int COORD_W     = 10;
    localparam int NUM_COEFS   = 9;
    localparam int DIV_STEPS   = 80;
    localparam int LOG2_MAX    = 8;

    localparam int TEX_DEPTH_DEF = 65536;
    localparam int MAX_SPAN_DEF  = 64;

    localparam logic [3:0]         WIDTH_LOG2_RST = 4'd6;
    localparam logic [3:0]         HEIGHT_LOG2_RST = 4'd6;
    localparam logic [COORD_W-1:0] ORIGIN_X_RST = 10'd160;
    localparam logic [COORD_W-1:0] ORIGIN_Y_RST = 10'd100;

    localparam logic [1:0] FUNC_LOAD_COEF = 2'd0;
    localparam logic [1:0] FUNC_WRITE_TEX = 2'd1;
    localparam logic [1:0] FUNC_PERSP     = 2'd2;
    localparam logic [1:0] FUNC_CONST     = 2'd3;

    localparam logic [1:0] CFG_WIDTH_LOG2  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT_LOG2 = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_X    = 2'd2;
    localparam logic [1:0] CFG_ORIGIN_Y    = 2'd3;

    localparam logic [1:0] PLANE_U = 2'd0;
    localparam logic [1:0] PLANE_V = 2'd1;
    localparam logic [1:0] PLANE_C = 2'd2;

    localparam logic [1:0] TERM_X     = 2'd0;
    localparam logic [1:0] TERM_Y     = 2'd1;
    localparam logic [1:0] TERM_CONST = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_PIX_START,
        S_DIV_WAIT,
        S_CDIV_START,
        S_CDIV_WAIT,
        S_ADDR,
        S_FETCH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       coef_wr;
        logic       tex_wr;
        logic       latch_span;
        logic       persp;
        logic       setup;
        logic [1:0] plane;
        logic [1:0] term;
        logic       div_start;
        logic       div_sh16;
        logic       div_deltas;
        logic       store_kl;
        logic       store_dkdl;
        logic       clear_steps;
        logic       addr_load;
        logic       fetch;
        logic       emit;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic c_zero;
        logic div_done;
        logic out_free;
    } t_stat;

    function automatic logic [ACC_W-1:0] sext48(input logic [COEF_W-1:0] v);
        return {{(ACC_W-COEF_W){v[COEF_W-1]}}, v};
    endfunction

    function automatic logic [3:0] clamp_log2(input logic [3:0] l);
        return (l > 4'(LOG2_MAX)) ? 4'(LOG2_MAX) : l;
    endfunction

endpackage
`default_nettype wire

@@ rtl/perspective_texture_span_core.sv @@
// Channel   | Handshake                    | Payload
// input     | i_in_valid / o_in_ready      | i_func, i_coef_index, i_coef_value, i_texel_addr,
//           |                              | i_texel_value, i_start_x, i_row_y, i_count
// output    | o_out_valid / i_out_ready    | o_pixel_x, o_pixel_y, o_color, o_div_zero, o_last
// config    | i_cfg_we                     | i_cfg_index, i_cfg_data
//
// A span's setup steps through every plane and term on one shared 11x48 multiplier; in
// perspective mode each pixel then waits on the 80-step restoring divider unless the
// denominator is zero, and constant-step mode first runs two 80-step divisions per span
// when its denominator is nonzero. Reset is synchronous and active low; the texture memory is not cleared.
// A stalled output holds the next pixel in the controller until the output register frees.
`default_nettype none
module perspective_texture_span_core #(
    parameter int TEX_DEPTH = ptsp_pkg::TEX_DEPTH_DEF,
    parameter int MAX_SPAN  = ptsp_pkg::MAX_SPAN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_func,
    input  wire logic [3:0]                    i_coef_index,
    input  wire logic [ptsp_pkg::COEF_W-1:0]   i_coef_value,
    input  wire logic [15:0]                   i_texel_addr,
    input  wire logic [7:0]                    i_texel_value,
    input  wire logic [ptsp_pkg::COORD_W-1:0]  i_start_x,
    input  wire logic [ptsp_pkg::COORD_W-1:0]  i_row_y,
    input  wire logic [ptsp_pkg::COUNT_W-1:0]  i_count,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ptsp_pkg::COORD_W-1:0]       o_pixel_x,
    output logic [ptsp_pkg::COORD_W-1:0]       o_pixel_y,
    output logic [7:0]                         o_color,
    output logic                               o_div_zero,
    output logic                               o_last,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [ptsp_pkg::COORD_W-1:0]  i_cfg_data
);
    import ptsp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ptsp_ctrl #(.MAX_SPAN(MAX_SPAN)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_count    (i_count),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptsp_datapath #(.TEX_DEPTH(TEX_DEPTH)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_coef_index  (i_coef_index),
        .i_coef_value  (i_coef_value),
        .i_texel_addr  (i_texel_addr),
        .i_texel_value (i_texel_value),
        .i_start_x     (i_start_x),
        .i_row_y       (i_row_y),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_color       (o_color),
        .o_div_zero    (o_div_zero),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

@@ rtl/ptsp_div.sv @@
`default_nettype none
module ptsp_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic                        i_sh16,
    input  wire logic [ptsp_pkg::ACC_W-1:0]  i_num_a,
    input  wire logic [ptsp_pkg::ACC_W-1:0]  i_num_b,
    input  wire logic [ptsp_pkg::ACC_W-1:0]  i_den,
    output logic                             o_done,
    output logic [ptsp_pkg::STEP_W-1:0]      o_q_a,
    output logic [ptsp_pkg::STEP_W-1:0]      o_q_b
);
    import ptsp_pkg::*;

    localparam int NUM_W = ACC_W + 16;

    logic                 r_busy, r_done;
    logic [6:0]           r_cnt;
    logic [ACC_W-1:0]     r_dm, r_ra, r_rb;
    logic [NUM_W-1:0]     r_na, r_nb;
    logic [STEP_W-1:0]    r_qa, r_qb, r_res_a, r_res_b;
    logic                 r_neg_a, r_neg_b;

    logic [ACC_W:0]       ta, tb;
    logic                 ge_a, ge_b;
    logic [ACC_W-1:0]     nra, nrb;
    logic [STEP_W-1:0]    nqa, nqb;
    logic [ACC_W-1:0]     abs_a, abs_b, abs_d;

    always_comb begin
        abs_a = i_num_a[ACC_W-1] ? (ACC_W'(0) - i_num_a) : i_num_a;
        abs_b = i_num_b[ACC_W-1] ? (ACC_W'(0) - i_num_b) : i_num_b;
        abs_d = i_den[ACC_W-1] ? (ACC_W'(0) - i_den) : i_den;
        ta    = {r_ra, r_na[NUM_W-1]};
        tb    = {r_rb, r_nb[NUM_W-1]};
        ge_a  = (ta >= {1'b0, r_dm});
        ge_b  = (tb >= {1'b0, r_dm});
        nra   = ge_a ? ACC_W'(ta - {1'b0, r_dm}) : ta[ACC_W-1:0];
        nrb   = ge_b ? ACC_W'(tb - {1'b0, r_dm}) : tb[ACC_W-1:0];
        nqa   = {r_qa[STEP_W-2:0], ge_a};
        nqb   = {r_qb[STEP_W-2:0], ge_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    // One restoring step per cycle on both lanes, sharing the divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dm    <= abs_d;
            r_na    <= i_sh16 ? {abs_a, 16'b0} : {16'b0, abs_a};
            r_nb    <= i_sh16 ? {abs_b, 16'b0} : {16'b0, abs_b};
            r_ra    <= '0;
            r_rb    <= '0;
            r_qa    <= '0;
            r_qb    <= '0;
            r_neg_a <= i_num_a[ACC_W-1] ^ i_den[ACC_W-1];
            r_neg_b <= i_num_b[ACC_W-1] ^ i_den[ACC_W-1];
        end else if (r_busy) begin
            r_na <= {r_na[NUM_W-2:0], 1'b0};
            r_nb <= {r_nb[NUM_W-2:0], 1'b0};
            r_ra <= nra;
            r_rb <= nrb;
            r_qa <= nqa;
            r_qb <= nqb;
            if (r_cnt == '0) begin
                r_res_a <= r_neg_a ? (STEP_W'(0) - nqa) : nqa;
                r_res_b <= r_neg_b ? (STEP_W'(0) - nqb) : nqb;
            end
        end
    end

    assign o_done = r_done;
    assign o_q_a  = r_res_a;
    assign o_q_b  = r_res_b;

endmodule
`default_nettype wire

@@ rtl/ptsp_datapath.sv @@
`default_nettype none
module ptsp_datapath #(
    parameter int TEX_DEPTH = ptsp_pkg::TEX_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ptsp_pkg::t_cmd                i_cmd,
    output ptsp_pkg::t_stat                    o_stat,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [ptsp_pkg::COORD_W-1:0]  i_cfg_data,
    input  wire logic [3:0]                    i_coef_index,
    input  wire logic [ptsp_pkg::COEF_W-1:0]   i_coef_value,
    input  wire logic [15:0]                   i_texel_addr,
    input  wire logic [7:0]                    i_texel_value,
    input  wire logic [ptsp_pkg::COORD_W-1:0]  i_start_x,
    input  wire logic [ptsp_pkg::COORD_W-1:0]  i_row_y,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [ptsp_pkg::COORD_W-1:0]       o_pixel_x,
    output logic [ptsp_pkg::COORD_W-1:0]       o_pixel_y,
    output logic [7:0]                         o_color,
    output logic                               o_div_zero,
    output logic                               o_last
);
    import ptsp_pkg::*;

    localparam int AW = $clog2(TEX_DEPTH);

    logic [3:0]         r_wl_cfg, r_hl_cfg;
    logic [COORD_W-1:0] r_ox, r_oy;
    logic [COEF_W-1:0]  r_coef [NUM_COEFS];
    logic [7:0]         r_tex_mem [TEX_DEPTH];
    logic [7:0]         r_tex_q;

    logic [COORD_W-1:0] r_px, r_py;
    logic [ACC_W-1:0]   r_acc, r_a, r_b, r_c;
    logic [STEP_W-1:0]  r_k, r_l, r_dk, r_dl;
    logic               r_zero_c, r_dz;
    logic [AW-1:0]      r_addr;

    logic               r_out_valid, r_out_dz, r_out_last;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic [7:0]         r_out_color;

    logic [3:0]         wl, hl;
    logic [8:0]         wm9, hm9;
    logic [ACC_W-1:0]   d_a, d_b, coef_ext, sum;
    logic [3:0]         coef_sel;
    logic signed [10:0] xs, ys, mul_a;
    logic signed [COEF_W-1:0] mul_b;
    logic signed [COEF_W+10:0] prod;
    logic [ACC_W-1:0]   prod64;
    logic               div_done;
    logic [STEP_W-1:0]  q_a, q_b;
    logic [7:0]         u, v;
    logic [16:0]        addr_full;

    always_comb begin
        wl       = clamp_log2(r_wl_cfg);
        hl       = clamp_log2(r_hl_cfg);
        wm9      = (9'd1 << wl) - 9'd1;
        hm9      = (9'd1 << hl) - 9'd1;
        d_a      = sext48(r_coef[0]) << wl;
        d_b      = sext48(r_coef[3]) << hl;
        xs       = signed'({1'b0, r_px} - {1'b0, r_ox});
        ys       = signed'({1'b0, r_py} - {1'b0, r_oy});
        coef_sel = 4'({i_cmd.plane, 1'b0}) + 4'(i_cmd.plane) + 4'(i_cmd.term);
        coef_ext = sext48(r_coef[coef_sel]);
        mul_a    = (i_cmd.term == TERM_X) ? xs : ys;
        mul_b    = signed'(r_coef[coef_sel]);
        prod     = mul_a * mul_b;
        prod64   = ACC_W'(prod);
        sum      = r_acc + coef_ext;
        if (i_cmd.persp) begin
            u = q_a[7:0] & wm9[7:0];
            v = q_b[7:0] & hm9[7:0];
        end else begin
            u = r_k[23:16] & wm9[7:0];
            v = r_l[23:16] & hm9[7:0];
        end
        addr_full = ({9'b0, v} << wl) + {9'b0, u};
    end

    ptsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_sh16  (i_cmd.div_sh16),
        .i_num_a (i_cmd.div_deltas ? d_a : r_a),
        .i_num_b (i_cmd.div_deltas ? d_b : r_b),
        .i_den   (r_c),
        .o_done  (div_done),
        .o_q_a   (q_a),
        .o_q_b   (q_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl_cfg <= WIDTH_LOG2_RST;
            r_hl_cfg <= HEIGHT_LOG2_RST;
            r_ox     <= ORIGIN_X_RST;
            r_oy     <= ORIGIN_Y_RST;
            for (int i = 0; i < NUM_COEFS; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH_LOG2:  r_wl_cfg <= i_cfg_data[3:0];
                    CFG_HEIGHT_LOG2: r_hl_cfg <= i_cfg_data[3:0];
                    CFG_ORIGIN_X:    r_ox <= i_cfg_data;
                    CFG_ORIGIN_Y:    r_oy <= i_cfg_data;
                    default:         r_ox <= r_ox;
                endcase
            end
            if (i_cmd.coef_wr && (i_coef_index < 4'(NUM_COEFS))) begin
                r_coef[i_coef_index] <= i_coef_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tex_wr) begin
            r_tex_mem[i_texel_addr[AW-1:0]] <= i_texel_value;
        end
        if (i_cmd.fetch) begin
            r_tex_q <= r_tex_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a      <= '0;
            r_b      <= '0;
            r_c      <= '0;
            r_k      <= '0;
            r_l      <= '0;
            r_dk     <= '0;
            r_dl     <= '0;
            r_zero_c <= 1'b0;
        end else begin
            if (i_cmd.latch_span) begin
                r_zero_c <= 1'b0;
            end
            if (i_cmd.setup && i_cmd.term == TERM_CONST) begin
                case (i_cmd.plane)
                    PLANE_U: r_a <= sum << wl;
                    PLANE_V: r_b <= sum << hl;
                    PLANE_C: r_c <= sum;
                    default: r_c <= sum;
                endcase
            end
            if (i_cmd.clear_steps) begin
                r_k      <= '0;
                r_l      <= '0;
                r_dk     <= '0;
                r_dl     <= '0;
                r_zero_c <= 1'b1;
            end
            if (i_cmd.store_kl) begin
                r_k <= q_a;
                r_l <= q_b;
            end
            if (i_cmd.store_dkdl) begin
                r_dk <= q_a;
                r_dl <= q_b;
            end
            if (i_cmd.addr_load) begin
                if (i_cmd.persp) begin
                    r_a <= r_a + d_a;
                    r_b <= r_b + d_b;
                    r_c <= r_c + sext48(r_coef[6]);
                end else begin
                    r_k <= r_k + r_dk;
                    r_l <= r_l + r_dl;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_span) begin
            r_px <= i_start_x;
            r_py <= i_row_y;
        end else if (i_cmd.emit) begin
            r_px <= r_px + COORD_W'(1);
        end
        if (i_cmd.setup) begin
            case (i_cmd.term)
                TERM_X:  r_acc <= (i_cmd.persp || i_cmd.plane != PLANE_C) ? prod64 : '0;
                TERM_Y:  r_acc <= r_acc + prod64;
                default: r_acc <= r_acc;
            endcase
        end
        if (i_cmd.addr_load) begin
            r_dz <= i_cmd.persp ? (r_c == '0) : r_zero_c;
            if ((i_cmd.persp && r_c == '0) || (!i_cmd.persp && r_zero_c)) begin
                r_addr <= '0;
            end else begin
                r_addr <= addr_full[AW-1:0];
            end
        end
    end

    // Output register: the next pixel is prepared while this one waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_x     <= r_px;
            r_out_y     <= r_py;
            r_out_color <= r_tex_q;
            r_out_dz    <= r_dz;
            r_out_last  <= i_cmd.last;
        end
    end

    always_comb begin
        o_stat.c_zero   = (r_c == '0);
        o_stat.div_done = div_done;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_out_x;
    assign o_pixel_y   = r_out_y;
    assign o_color     = r_out_color;
    assign o_div_zero  = r_out_dz;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

@@ rtl/ptsp_ctrl.sv @@
`default_nettype none
module ptsp_ctrl #(
    parameter int MAX_SPAN = ptsp_pkg::MAX_SPAN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_func,
    input  wire logic [ptsp_pkg::COUNT_W-1:0]  i_count,
    input  wire ptsp_pkg::t_stat               i_stat,
    output ptsp_pkg::t_cmd                     o_cmd
);
    import ptsp_pkg::*;

    t_state             r_state, n_state;
    logic [1:0]         r_plane, r_term;
    logic [COUNT_W-1:0] r_left, n_left;
    logic               r_persp, r_phase;
    logic               accept, is_span;
    logic [COUNT_W-1:0] sat_count;

    always_comb begin
        accept    = i_in_valid && (r_state == S_IDLE);
        is_span   = (i_func == FUNC_PERSP) || (i_func == FUNC_CONST);
        sat_count = (i_count > COUNT_W'(MAX_SPAN)) ? COUNT_W'(MAX_SPAN) : i_count;
    end

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        case (r_state)
            S_IDLE: begin
                if (accept && is_span && sat_count != '0) begin
                    n_state = S_SETUP;
                    n_left  = sat_count;
                end
            end
            S_SETUP: begin
                if (r_plane == PLANE_C && r_term == TERM_CONST) begin
                    n_state = r_persp ? S_PIX_START : S_CDIV_START;
                end
            end
            S_PIX_START: n_state = i_stat.c_zero ? S_ADDR : S_DIV_WAIT;
            S_DIV_WAIT:  if (i_stat.div_done) n_state = S_ADDR;
            S_CDIV_START: begin
                n_state = (!r_phase && i_stat.c_zero) ? S_ADDR : S_CDIV_WAIT;
            end
            S_CDIV_WAIT: begin
                if (i_stat.div_done) n_state = r_phase ? S_ADDR : S_CDIV_START;
            end
            S_ADDR:  n_state = S_FETCH;
            S_FETCH: n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_left = r_left - COUNT_W'(1);
                    if (r_left == COUNT_W'(1)) n_state = S_IDLE;
                    else n_state = r_persp ? S_PIX_START : S_ADDR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.persp      = r_persp;
        o_cmd.plane      = r_plane;
        o_cmd.term       = r_term;
        o_cmd.last       = (r_left == COUNT_W'(1));
        o_in_ready       = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.coef_wr    = accept && (i_func == FUNC_LOAD_COEF);
                o_cmd.tex_wr     = accept && (i_func == FUNC_WRITE_TEX);
                o_cmd.latch_span = accept && is_span;
            end
            S_SETUP:     o_cmd.setup = 1'b1;
            S_PIX_START: o_cmd.div_start = !i_stat.c_zero;
            S_CDIV_START: begin
                o_cmd.div_sh16    = 1'b1;
                o_cmd.div_deltas  = r_phase;
                o_cmd.clear_steps = !r_phase && i_stat.c_zero;
                o_cmd.div_start   = r_phase || !i_stat.c_zero;
            end
            S_CDIV_WAIT: begin
                o_cmd.store_kl   = i_stat.div_done && !r_phase;
                o_cmd.store_dkdl = i_stat.div_done && r_phase;
            end
            S_ADDR:  o_cmd.addr_load = 1'b1;
            S_FETCH: o_cmd.fetch = 1'b1;
            S_EMIT:  o_cmd.emit = i_stat.out_free;
            default: o_cmd.setup = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_plane <= PLANE_U;
            r_term  <= TERM_X;
            r_persp <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            if (accept && is_span) begin
                r_persp <= (i_func == FUNC_PERSP);
                r_plane <= PLANE_U;
                r_term  <= TERM_X;
                r_phase <= 1'b0;
            end else if (r_state == S_SETUP) begin
                if (r_term == TERM_CONST) begin
                    r_term  <= TERM_X;
                    r_plane <= r_plane + 2'd1;
                end else begin
                    r_term <= r_term + 2'd1;
                end
            end
            if (r_state == S_CDIV_WAIT && i_stat.div_done) begin
                r_phase <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/tb_perspective_texture_span_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_perspective_texture_span_core;
    import ptsp_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES = 1500;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 20;
    localparam int TEXELS = 256;

    typedef struct packed {
        logic [9:0] x;
        logic [9:0] y;
        logic [7:0] color;
        logic       dz;
        logic       last;
    } t_pixel;

    typedef struct {
        logic [1:0]  fn;
        logic [3:0]  idx;
        logic [47:0] val;
        logic [15:0] addr;
        logic [7:0]  tv;
        logic [9:0]  sx;
        logic [9:0]  ry;
        logic [6:0]  cnt;
        bit          typed;
        logic [7:0]  tcolor;
        logic        tdz;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [3:0]  i_coef_index;
    logic [47:0] i_coef_value;
    logic [15:0] i_texel_addr;
    logic [7:0]  i_texel_value;
    logic [9:0]  i_start_x;
    logic [9:0]  i_row_y;
    logic [6:0]  i_count;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [9:0]  o_pixel_x;
    logic [9:0]  o_pixel_y;
    logic [7:0]  o_color;
    logic        o_div_zero;
    logic        o_last;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;

    perspective_texture_span_core DUT (.*);

    // Shadow state of the span unit.
    logic [63:0] coefs [NUM_COEFS];
    logic [7:0]  texels [65536];
    logic [3:0]  width_log2;
    logic [3:0]  height_log2;
    logic [9:0]  org_x;
    logic [9:0]  org_y;

    t_pixel      expected_pixels [$];
    int          errors;
    int          pixels_seen;
    int          cycles;
    bit          quiet;
    bit          hold_done;
    t_stim_row   dir_rows [22];

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_perspective_texture_span_core failed");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, exp, cycles);
        errors++;
    endtask

    function automatic logic [63:0] quot_trunc(input logic [63:0] num, input logic [63:0] den,
                                               input int sh);
        logic        neg;
        logic [63:0] nm;
        logic [63:0] dm;
        logic [127:0] q;
        neg = num[63] ^ den[63];
        nm = num[63] ? 64'd0 - num : num;
        dm = den[63] ? 64'd0 - den : den;
        q = ({64'd0, nm} << sh) / {64'd0, dm};
        return neg ? 64'd0 - q[63:0] : q[63:0];
    endfunction

    function automatic logic [7:0] texel_at(input logic [31:0] u, input logic [31:0] v,
                                            input logic [3:0] wl);
        logic [31:0] a;
        a = (v << wl) + u;
        return texels[a[15:0]];
    endfunction

    // Works out the pixels of one accepted item and updates the shadow state.
    task automatic predict_pixels(input t_stim_row r);
        logic [3:0]  wl;
        logic [3:0]  hl;
        logic [31:0] wm;
        logic [31:0] hm;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] acc_a;
        logic [63:0] acc_b;
        logic [63:0] acc_c;
        logic [63:0] da;
        logic [63:0] db;
        logic [31:0] k;
        logic [31:0] l;
        logic [31:0] dk;
        logic [31:0] dl;
        logic        zero_c;
        int          n;
        t_pixel      p;
        if (r.fn == FUNC_LOAD_COEF) begin
            if (r.idx < NUM_COEFS) coefs[r.idx] = {{16{r.val[47]}}, r.val};
            return;
        end
        if (r.fn == FUNC_WRITE_TEX) begin
            texels[r.addr] = r.tv;
            return;
        end
        wl = (width_log2 > 4'd8) ? 4'd8 : width_log2;
        hl = (height_log2 > 4'd8) ? 4'd8 : height_log2;
        wm = (32'd1 << wl) - 32'd1;
        hm = (32'd1 << hl) - 32'd1;
        x = {54'd0, r.sx} - {54'd0, org_x};
        y = {54'd0, r.ry} - {54'd0, org_y};
        acc_a = (x * coefs[0] + y * coefs[1] + coefs[2]) << wl;
        acc_b = (x * coefs[3] + y * coefs[4] + coefs[5]) << hl;
        da = coefs[0] << wl;
        db = coefs[3] << hl;
        zero_c = 1'b0;
        k = '0;
        l = '0;
        dk = '0;
        dl = '0;
        if (r.fn == FUNC_PERSP) begin
            acc_c = x * coefs[6] + y * coefs[7] + coefs[8];
        end else begin
            acc_c = y * coefs[7] + coefs[8];
            zero_c = (acc_c == 64'd0);
            if (!zero_c) begin
                k = 32'(quot_trunc(acc_a, acc_c, 16));
                l = 32'(quot_trunc(acc_b, acc_c, 16));
                dk = 32'(quot_trunc(da, acc_c, 16));
                dl = 32'(quot_trunc(db, acc_c, 16));
            end
        end
        n = (r.cnt > 7'd64) ? 64 : int'(r.cnt);
        for (int i = 0; i < n; i++) begin
            p.x = r.sx + 10'(i);
            p.y = r.ry;
            p.last = (i == n - 1);
            if (r.fn == FUNC_PERSP) begin
                p.dz = (acc_c == 64'd0);
                if (p.dz) p.color = texels[0];
                else p.color = texel_at(32'(quot_trunc(acc_a, acc_c, 0)) & wm,
                                        32'(quot_trunc(acc_b, acc_c, 0)) & hm, wl);
                acc_a += da;
                acc_b += db;
                acc_c += coefs[6];
            end else begin
                p.dz = zero_c;
                if (p.dz) p.color = texels[0];
                else p.color = texel_at((k >> 16) & wm, (l >> 16) & hm, wl);
                k += dk;
                l += dl;
            end
            if (r.typed) begin
                p.color = r.tcolor;
                p.dz = r.tdz;
            end
            expected_pixels.push_back(p);
        end
    endtask

    // Offers one item and predicts it at the edge where the transfer happens.
    task automatic send_item(input t_stim_row r);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= r.fn;
        i_coef_index <= r.idx;
        i_coef_value <= r.val;
        i_texel_addr <= r.addr;
        i_texel_value <= r.tv;
        i_start_x <= r.sx;
        i_row_y <= r.ry;
        i_count <= r.cnt;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pixels(r);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [9:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_WIDTH_LOG2:  width_log2 = data[3:0];
            CFG_HEIGHT_LOG2: height_log2 = data[3:0];
            CFG_ORIGIN_X:    org_x = data;
            default:         org_y = data;
        endcase
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_stim_row row(input logic [1:0] fn, input logic [3:0] idx,
                                      input logic [47:0] val, input logic [15:0] addr,
                                      input logic [7:0] tv, input logic [9:0] sx,
                                      input logic [9:0] ry, input logic [6:0] cnt);
        t_stim_row r;
        r = '{fn, idx, val, addr, tv, sx, ry, cnt, 1'b0, 8'd0, 1'b0};
        return r;
    endfunction

    function automatic logic [47:0] rand_coef();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return v;
            2:       return 48'(32'd1 << $urandom_range(10, 24));
            default: return {{28{v[19]}}, v[19:0]};
        endcase
    endfunction

    function automatic t_stim_row rand_row();
        t_stim_row r;
        int        pick;
        r = row(2'($urandom_range(0, 3)), 4'($urandom_range(0, 8)), rand_coef(),
                16'($urandom), 8'($urandom), 10'($urandom), 10'($urandom),
                7'($urandom_range(1, 8)));
        pick = $urandom_range(0, 99);
        if (pick < 5) r.cnt = 7'd0;
        else if (pick < 10) r.cnt = 7'($urandom_range(9, 127));
        if ($urandom_range(0, 9) == 0) r.idx = 4'($urandom_range(9, 15));
        // Keep denominators mostly large and positive so quotients stay meaningful.
        if (r.fn == FUNC_LOAD_COEF && r.idx == 4'd8 && $urandom_range(0, 3) != 0)
            r.val = 48'($urandom_range(1 << 16, 1 << 26));
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            pixels_seen <= pixels_seen + 1;
            if (expected_pixels.size() == 0) begin
                report("unexpected pixel", 64'({o_pixel_x, o_pixel_y}), 64'd0);
            end else begin
                t_pixel p;
                p = expected_pixels.pop_front();
                if (o_pixel_x !== p.x) report("pixel_x", 64'(o_pixel_x), 64'(p.x));
                if (o_pixel_y !== p.y) report("pixel_y", 64'(o_pixel_y), 64'(p.y));
                if (o_color !== p.color) report("color", 64'(o_color), 64'(p.color));
                if (o_div_zero !== p.dz) report("div_zero", 64'(o_div_zero), 64'(p.dz));
                if (o_last !== p.last) report("last", 64'(o_last), 64'(p.last));
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off while items keep coming.
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && pixels_seen >= 40) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [7:0] pat;
        logic [3:0] wsel;
        logic [3:0] hsel;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_out_ready <= 1'b0;
        i_func <= FUNC_LOAD_COEF;
        i_coef_index <= '0;
        i_coef_value <= '0;
        i_texel_addr <= '0;
        i_texel_value <= '0;
        i_start_x <= '0;
        i_row_y <= '0;
        i_count <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_WIDTH_LOG2;
        i_cfg_data <= '0;
        errors = 0;
        pixels_seen = 0;
        cycles = 0;
        quiet = 1'b1;
        hold_done = 1'b0;
        for (int i = 0; i < NUM_COEFS; i++) coefs[i] = '0;
        width_log2 = WIDTH_LOG2_RST;
        height_log2 = HEIGHT_LOG2_RST;
        org_x = ORIGIN_X_RST;
        org_y = ORIGIN_Y_RST;

        // Coefficients are all zero after reset, so spans see a zero denominator.
        dir_rows[0] = row(FUNC_PERSP, 0, 0, 0, 0, 0, 0, 1);
        dir_rows[0].typed = 1'b1; dir_rows[0].tcolor = 8'h5A; dir_rows[0].tdz = 1'b1;
        dir_rows[1] = row(FUNC_CONST, 0, 0, 0, 0, 1023, 1023, 3);
        dir_rows[1].typed = 1'b1; dir_rows[1].tcolor = 8'h5A; dir_rows[1].tdz = 1'b1;
        dir_rows[2] = row(FUNC_PERSP, 0, 0, 0, 0, 5, 5, 0);
        dir_rows[3] = row(FUNC_LOAD_COEF, 9, 48'h7FFF_FFFF_FFFF, 0, 0, 0, 0, 0);
        dir_rows[4] = row(FUNC_LOAD_COEF, 15, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0);
        dir_rows[5] = row(FUNC_LOAD_COEF, 0, 48'h7FFF_FFFF_FFFF, 0, 0, 0, 0, 0);
        dir_rows[6] = row(FUNC_LOAD_COEF, 1, 48'h8000_0000_0000, 0, 0, 0, 0, 0);
        dir_rows[7] = row(FUNC_LOAD_COEF, 2, 48'd0, 0, 0, 0, 0, 0);
        dir_rows[8] = row(FUNC_LOAD_COEF, 3, 48'd65536, 0, 0, 0, 0, 0);
        dir_rows[9] = row(FUNC_LOAD_COEF, 4, -48'sd65536, 0, 0, 0, 0, 0);
        dir_rows[10] = row(FUNC_LOAD_COEF, 5, 48'd12345, 0, 0, 0, 0, 0);
        dir_rows[11] = row(FUNC_LOAD_COEF, 6, 48'd0, 0, 0, 0, 0, 0);
        dir_rows[12] = row(FUNC_LOAD_COEF, 7, 48'd3, 0, 0, 0, 0, 0);
        dir_rows[13] = row(FUNC_LOAD_COEF, 8, 48'd65536, 0, 0, 0, 0, 0);
        dir_rows[14] = row(FUNC_PERSP, 0, 0, 0, 0, 100, 90, 64);
        dir_rows[15] = row(FUNC_CONST, 0, 0, 0, 0, 200, 110, 127);
        dir_rows[16] = row(FUNC_PERSP, 0, 0, 0, 0, 1020, 7, 8);
        dir_rows[17] = row(FUNC_WRITE_TEX, 0, 0, 16'hFFFF, 8'h00, 0, 0, 0);
        dir_rows[18] = row(FUNC_WRITE_TEX, 0, 0, 16'h0000, 8'hFF, 0, 0, 0);
        dir_rows[19] = row(FUNC_LOAD_COEF, 8, 48'd0, 0, 0, 0, 0, 0);
        // With a zero constant-mode denominator the whole span reads texel zero.
        dir_rows[20] = row(FUNC_CONST, 0, 0, 0, 0, 300, 100, 4);
        dir_rows[20].typed = 1'b1; dir_rows[20].tcolor = 8'hFF; dir_rows[20].tdz = 1'b1;
        // The denominator steps through zero in the middle of this span.
        dir_rows[21] = row(FUNC_PERSP, 0, 0, 0, 0, 160, 100, 5);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // This loop writes the first 256 texels, and every texture size set
        // below keeps width times height within them.
        for (int a = 0; a < TEXELS; a++) begin
            pat = a[7:0] ^ a[15:8] ^ 8'h5A;
            send_item(row(FUNC_WRITE_TEX, 0, 0, a[15:0], pat, 0, 0, 0));
        end
        quiet = 1'b0;

        foreach (dir_rows[i]) begin
            if (i == 3) begin
                wait_idle();
                write_cfg(CFG_WIDTH_LOG2, 10'd4);
                write_cfg(CFG_HEIGHT_LOG2, 10'd4);
                i_cfg_we <= 1'b0;
            end
            send_item(dir_rows[i]);
        end
        send_item(row(FUNC_LOAD_COEF, 6, 48'd1, 0, 0, 0, 0, 0));
        send_item(row(FUNC_LOAD_COEF, 7, 48'd0, 0, 0, 0, 0, 0));
        send_item(row(FUNC_LOAD_COEF, 8, -48'sd2, 0, 0, 0, 0, 0));
        send_item(dir_rows[21]);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    write_cfg(CFG_WIDTH_LOG2, 10'd0);
                    write_cfg(CFG_HEIGHT_LOG2, 10'd0);
                    write_cfg(CFG_ORIGIN_X, 10'd0);
                    write_cfg(CFG_ORIGIN_Y, 10'd0);
                end
                1: begin
                    write_cfg(CFG_WIDTH_LOG2, 10'h3FF);
                    write_cfg(CFG_HEIGHT_LOG2, 10'd0);
                    write_cfg(CFG_ORIGIN_X, 10'd1023);
                    write_cfg(CFG_ORIGIN_Y, 10'd1023);
                end
                2: begin
                    write_cfg(CFG_WIDTH_LOG2, 10'h3F0);
                    write_cfg(CFG_HEIGHT_LOG2, 10'd12);
                    write_cfg(CFG_ORIGIN_X, 10'd512);
                    write_cfg(CFG_ORIGIN_Y, 10'd7);
                end
                default: begin
                    wsel = 4'($urandom_range(0, 15));
                    hsel = 4'($urandom_range(0, 8 - ((wsel > 4'd8) ? 8 : int'(wsel))));
                    write_cfg(CFG_WIDTH_LOG2, {6'($urandom), wsel});
                    write_cfg(CFG_HEIGHT_LOG2, {6'($urandom), hsel});
                    write_cfg(CFG_ORIGIN_X, 10'($urandom));
                    write_cfg(CFG_ORIGIN_Y, 10'($urandom));
                end
            endcase
            i_cfg_we <= 1'b0;
            if (ph == PHASES - 1) quiet = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_row());
            wait_idle();
        end

        if (errors == 0) begin
            $display("tb_perspective_texture_span_core passed");
        end else begin
            $display("tb_perspective_texture_span_core failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
